// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the lexer RTL.
// Depends on nothing; define SYNTHESIS to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JBL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define JBL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define JBL_ASSERT(label, clk, rst_n, prop)
`define JBL_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/jbl_pkg.sv =====
// Package for the JSON byte stream lexer: token codes, modes, result bundle.
// No dependencies.
package jbl_pkg;

  localparam int unsigned LineCountWidth = 32;

  typedef enum logic [3:0] {
    TK_LBRACKET = 4'd0,
    TK_LBRACE   = 4'd1,
    TK_COLON    = 4'd2,
    TK_COMMA    = 4'd3,
    TK_RBRACE   = 4'd4,
    TK_RBRACKET = 4'd5,
    TK_STR_END  = 4'd6,
    TK_NUM_END  = 4'd7,
    TK_TRUE     = 4'd8,
    TK_FALSE    = 4'd9,
    TK_NULL     = 4'd10,
    TK_EOF      = 4'd11,
    TK_ERROR    = 4'd12,
    TK_CONTENT  = 4'd13
  } token_kind_e;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_STRING  = 3'd1,
    M_ESCAPE  = 3'd2,
    M_HEX     = 3'd3,
    M_LITERAL = 3'd4,
    M_NUMBER  = 3'd5,
    M_SLASH   = 3'd6,
    M_COMMENT = 3'd7
  } lex_mode_e;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
  } token_t;

  // One input's worth of results: up to three tokens sharing a line number.
  typedef struct packed {
    logic [1:0]  count;   // 1..3
    token_t [2:0] tok;    // tok[0] first
    logic [31:0] line;
  } bundle_t;

  localparam int unsigned BundleWidth = $bits(bundle_t);
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueueAw     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCw     = $clog2(QueueDepth + 1);

endpackage

// ===== rtl/jbl_front.sv =====
// Front end: accepts bytes, runs the lexer state, packs results into a bundle.
// Depends on jbl_pkg.
module jbl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         text_byte_i,
  input  logic               is_end_i,
  output logic               push_o,
  output jbl_pkg::bundle_t   bundle_o,
  input  logic               full_i
);

  jbl_pkg::lex_mode_e mode_q, mode_d;
  logic [2:0]  lpos_q, lpos_d;
  logic [1:0]  lword_q, lword_d;
  logic [2:0]  nphase_q, nphase_d;
  logic [15:0] hacc_q, hacc_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [1:0]  upend_q, upend_d;
  logic [2:0]  uclass_q, uclass_d;
  logic [jbl_pkg::LineCountWidth-1:0] line_q, line_d;
  logic        err_q, err_d;

  logic        fire;
  logic [1:0]  n;
  jbl_pkg::token_t [2:0] tk;
  logic [31:0] line_snap;

  assign in_ready_o = !full_i;
  assign fire = in_valid_i && in_ready_o;

  function automatic logic num_complete(input logic [2:0] p);
    return (p == 3'd1) || (p == 3'd2) || (p == 3'd4) || (p == 3'd7);
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
    logic [7:0] r;
    r = 8'h00;
    unique case (w)
      2'd0: unique case (p)
              3'd0: r = "r"; 3'd1: r = "u"; 3'd2: r = "e"; default: r = 8'h00;
            endcase
      2'd1: unique case (p)
              3'd0: r = "a"; 3'd1: r = "l"; 3'd2: r = "s"; 3'd3: r = "e";
              default: r = 8'h00;
            endcase
      2'd2: unique case (p)
              3'd0: r = "u"; 3'd1: r = "l"; 3'd2: r = "l"; default: r = 8'h00;
            endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  always_comb begin
    logic [7:0]  c;
    logic        dig, ex, hexok, nx_ok, lit_ok;
    logic [3:0]  hv;
    logic [2:0]  nx;
    logic [2:0]  llen;
    logic [7:0]  lo, hi;
    logic [15:0] x;
    logic        idle_pass;
    logic [63:0] lwide;
    c = text_byte_i;
    mode_d = mode_q; lpos_d = lpos_q; lword_d = lword_q; nphase_d = nphase_q;
    hacc_d = hacc_q; hcnt_d = hcnt_q; upend_d = upend_q; uclass_d = uclass_q;
    line_d = line_q; err_d = err_q;
    n = 2'd0;
    tk = '0;
    idle_pass = 1'b0;
    dig = (c >= "0") && (c <= "9");
    ex = (c == "e") || (c == "E");
    hexok = 1'b1; hv = 4'd0;
    if (dig) hv = 4'(c - "0");
    else if (c >= "A" && c <= "F") hv = 4'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "f") hv = 4'(c - "a" + 8'd10);
    else hexok = 1'b0;
    nx = 3'd0; nx_ok = 1'b0;
    llen = (lword_q == 2'd1) ? 3'd4 : 3'd3;
    lit_ok = 1'b0;
    lo = 8'h80; hi = 8'hBF;
    x = {hacc_q[11:0], hv};
    // line number on the port saturates at 32 bits
    lwide = 64'(line_q);
    line_snap = (lwide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lwide[31:0];

    if (is_end_i) begin
      if (!err_q) begin
        if (mode_q == jbl_pkg::M_NUMBER) begin
          tk[0].kind = num_complete(nphase_q) ? jbl_pkg::TK_NUM_END : jbl_pkg::TK_ERROR;
          n = 2'd1;
        end else if (mode_q != jbl_pkg::M_IDLE && mode_q != jbl_pkg::M_COMMENT) begin
          tk[0].kind = jbl_pkg::TK_ERROR;
          n = 2'd1;
        end
      end
      tk[n].kind = jbl_pkg::TK_EOF;
      n = n + 2'd1;
      mode_d = jbl_pkg::M_IDLE; lpos_d = '0; lword_d = '0; nphase_d = '0;
      hacc_d = '0; hcnt_d = '0; upend_d = '0; uclass_d = '0; line_d = '0; err_d = 1'b0;
    end else if (!err_q) begin
      unique case (mode_q)
        jbl_pkg::M_NUMBER: begin
          unique case (nphase_q)
            3'd0: begin nx_ok = dig; nx = (c == "0") ? 3'd1 : 3'd2; end
            3'd1: begin nx_ok = (c == ".") || ex; nx = (c == ".") ? 3'd3 : 3'd5; end
            3'd2: begin
              nx_ok = dig || (c == ".") || ex;
              nx = dig ? 3'd2 : ((c == ".") ? 3'd3 : 3'd5);
            end
            3'd3: begin nx_ok = dig; nx = 3'd4; end
            3'd4: begin nx_ok = dig || ex; nx = dig ? 3'd4 : 3'd5; end
            3'd5: begin
              nx_ok = dig || (c == "+") || (c == "-");
              nx = dig ? 3'd7 : 3'd6;
            end
            default: begin nx_ok = dig; nx = 3'd7; end
          endcase
          if (nx_ok) begin
            nphase_d = nx;
            tk[0] = '{kind: jbl_pkg::TK_CONTENT, data: c};
            n = 2'd1;
          end else if (num_complete(nphase_q)) begin
            tk[0].kind = jbl_pkg::TK_NUM_END;
            n = 2'd1;
            mode_d = jbl_pkg::M_IDLE; nphase_d = '0;
            idle_pass = 1'b1;
          end else begin
            tk[0].kind = jbl_pkg::TK_ERROR; n = 2'd1; err_d = 1'b1;
            mode_d = jbl_pkg::M_IDLE; nphase_d = '0;
          end
        end
        jbl_pkg::M_IDLE: idle_pass = 1'b1;
        jbl_pkg::M_STRING: begin
          if (upend_q != 2'd0) begin
            unique case (uclass_q)
              3'd1: lo = 8'hA0;
              3'd2: hi = 8'h9F;
              3'd3: lo = 8'h90;
              3'd4: hi = 8'h8F;
              default: ;
            endcase
            if (c < lo || c > hi) begin
              tk[0].kind = jbl_pkg::TK_ERROR; n = 2'd1; err_d = 1'b1;
              mode_d = jbl_pkg::M_IDLE; upend_d = '0; uclass_d = '0;
            end else begin
              upend_d = upend_q - 2'd1; uclass_d = '0;
              tk[0] = '{kind: jbl_pkg::TK_CONTENT, data: c}; n = 2'd1;
            end
          end else if (c < 8'h20) begin
            tk[0].kind = jbl_pkg::TK_ERROR; n = 2'd1; err_d = 1'b1;
            mode_d = jbl_pkg::M_IDLE;
          end else if (c == "\"") begin
            tk[0].kind = jbl_pkg::TK_STR_END; n = 2'd1; mode_d = jbl_pkg::M_IDLE;
          end else if (c == "\\") begin
            mode_d = jbl_pkg::M_ESCAPE;
          end else if (c < 8'h80) begin
            tk[0] = '{kind: jbl_pkg::TK_CONTENT, data: c}; n = 2'd1;
          end else begin
            tk[0] = '{kind: jbl_pkg::TK_CONTENT, data: c}; n = 2'd1;
            if (c >= 8'hC2 && c <= 8'hDF) begin upend_d = 2'd1; uclass_d = 3'd0; end
            else if (c == 8'hE0) begin upend_d = 2'd2; uclass_d = 3'd1; end
            else if (c == 8'hED) begin upend_d = 2'd2; uclass_d = 3'd2; end
            else if (c >= 8'hE1 && c <= 8'hEF) begin upend_d = 2'd2; uclass_d = 3'd0; end
            else if (c == 8'hF0) begin upend_d = 2'd3; uclass_d = 3'd3; end
            else if (c >= 8'hF1 && c <= 8'hF3) begin upend_d = 2'd3; uclass_d = 3'd0; end
            else if (c == 8'hF4) begin upend_d = 2'd3; uclass_d = 3'd4; end
            else begin
              tk[0] = '{kind: jbl_pkg::TK_ERROR, data: 8'h00}; err_d = 1'b1;
              mode_d = jbl_pkg::M_IDLE;
            end
          end
        end
        jbl_pkg::M_ESCAPE: begin
          mode_d = jbl_pkg::M_STRING; n = 2'd1;
          tk[0].kind = jbl_pkg::TK_CONTENT;
          unique case (c)
            "\"", "\\", "/": tk[0].data = c;
            "b": tk[0].data = 8'h08;
            "f": tk[0].data = 8'h0C;
            "n": tk[0].data = 8'h0A;
            "r": tk[0].data = 8'h0D;
            "t": tk[0].data = 8'h09;
            "u": begin
              n = 2'd0; mode_d = jbl_pkg::M_HEX; hacc_d = '0; hcnt_d = '0;
            end
            default: begin
              tk[0].kind = jbl_pkg::TK_ERROR; err_d = 1'b1; mode_d = jbl_pkg::M_IDLE;
            end
          endcase
        end
        jbl_pkg::M_HEX: begin
          if (!hexok) begin
            tk[0].kind = jbl_pkg::TK_ERROR; n = 2'd1; err_d = 1'b1;
            mode_d = jbl_pkg::M_IDLE; hacc_d = '0; hcnt_d = '0;
          end else if (hcnt_q != 3'd3) begin
            hacc_d = x; hcnt_d = hcnt_q + 3'd1;
          end else begin
            hacc_d = '0; hcnt_d = '0;
            if (x >= 16'hD800 && x <= 16'hDFFF) begin
              tk[0].kind = jbl_pkg::TK_ERROR; n = 2'd1; err_d = 1'b1;
              mode_d = jbl_pkg::M_IDLE;
            end else begin
              mode_d = jbl_pkg::M_STRING;
              tk[0].kind = jbl_pkg::TK_CONTENT;
              tk[1].kind = jbl_pkg::TK_CONTENT;
              tk[2].kind = jbl_pkg::TK_CONTENT;
              if (x < 16'h0080) begin
                n = 2'd1; tk[0].data = x[7:0];
              end else if (x < 16'h0800) begin
                n = 2'd2;
                tk[0].data = {3'b110, x[10:6]};
                tk[1].data = {2'b10, x[5:0]};
              end else begin
                n = 2'd3;
                tk[0].data = {4'b1110, x[15:12]};
                tk[1].data = {2'b10, x[11:6]};
                tk[2].data = {2'b10, x[5:0]};
              end
            end
          end
        end
        jbl_pkg::M_LITERAL: begin
          lit_ok = (lword_q != 2'd3) && (lpos_q < llen) && (c == lit_char(lword_q, lpos_q));
          if (!lit_ok) begin
            tk[0].kind = jbl_pkg::TK_ERROR; n = 2'd1; err_d = 1'b1;
            mode_d = jbl_pkg::M_IDLE; lpos_d = '0; lword_d = '0;
          end else if (lpos_q + 3'd1 == llen) begin
            n = 2'd1;
            tk[0].kind = (lword_q == 2'd0) ? jbl_pkg::TK_TRUE :
                         (lword_q == 2'd1) ? jbl_pkg::TK_FALSE : jbl_pkg::TK_NULL;
            mode_d = jbl_pkg::M_IDLE; lpos_d = '0; lword_d = '0;
          end else begin
            lpos_d = lpos_q + 3'd1;
          end
        end
        jbl_pkg::M_SLASH: begin
          if (c == "/") mode_d = jbl_pkg::M_COMMENT;
          else begin
            tk[0].kind = jbl_pkg::TK_ERROR; n = 2'd1; err_d = 1'b1;
            mode_d = jbl_pkg::M_IDLE;
          end
        end
        default: begin
          if (c == 8'h0A) begin
            mode_d = jbl_pkg::M_IDLE;
            if (line_q != '1) line_d = line_q + 1'b1;
          end
        end
      endcase

      // Byte lexed from idle, possibly right after a number end.
      if (idle_pass) begin
        unique case (c)
          "[": begin tk[n].kind = jbl_pkg::TK_LBRACKET; n = n + 2'd1; end
          "{": begin tk[n].kind = jbl_pkg::TK_LBRACE; n = n + 2'd1; end
          ":": begin tk[n].kind = jbl_pkg::TK_COLON; n = n + 2'd1; end
          ",": begin tk[n].kind = jbl_pkg::TK_COMMA; n = n + 2'd1; end
          "}": begin tk[n].kind = jbl_pkg::TK_RBRACE; n = n + 2'd1; end
          "]": begin tk[n].kind = jbl_pkg::TK_RBRACKET; n = n + 2'd1; end
          " ", 8'h09, 8'h0D: ;
          8'h0A: if (line_q != '1) line_d = line_q + 1'b1;
          "\"": mode_d = jbl_pkg::M_STRING;
          "t": begin mode_d = jbl_pkg::M_LITERAL; lpos_d = '0; lword_d = 2'd0; end
          "f": begin mode_d = jbl_pkg::M_LITERAL; lpos_d = '0; lword_d = 2'd1; end
          "n": begin mode_d = jbl_pkg::M_LITERAL; lpos_d = '0; lword_d = 2'd2; end
          "/": mode_d = jbl_pkg::M_SLASH;
          default: begin
            if (c == "-" || dig) begin
              mode_d = jbl_pkg::M_NUMBER;
              nphase_d = (c == "-") ? 3'd0 : ((c == "0") ? 3'd1 : 3'd2);
              tk[n] = '{kind: jbl_pkg::TK_CONTENT, data: c};
              n = n + 2'd1;
            end else begin
              tk[n] = '{kind: jbl_pkg::TK_ERROR, data: 8'h00};
              n = n + 2'd1;
              err_d = 1'b1;
              mode_d = jbl_pkg::M_IDLE; nphase_d = '0;
            end
          end
        endcase
      end
    end
  end

  assign push_o = fire && (n != 2'd0);
  assign bundle_o = '{count: n, tok: tk, line: line_snap};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jbl_pkg::M_IDLE;
      lpos_q <= '0; lword_q <= '0; nphase_q <= '0; hacc_q <= '0; hcnt_q <= '0;
      upend_q <= '0; uclass_q <= '0; line_q <= '0; err_q <= 1'b0;
    end else if (fire) begin
      mode_q <= mode_d;
      lpos_q <= lpos_d; lword_q <= lword_d; nphase_q <= nphase_d;
      hacc_q <= hacc_d; hcnt_q <= hcnt_d; upend_q <= upend_d; uclass_q <= uclass_d;
      line_q <= line_d; err_q <= err_d;
    end
  end

  `include "assert_macros.svh"
  `JBL_ASSERT(a_err_idle, clk_i, rst_ni, !err_q || mode_q == jbl_pkg::M_IDLE)
  `JBL_ASSERT(a_push_safe, clk_i, rst_ni, !push_o || !full_i)
  `JBL_ASSERT(a_end_clears, clk_i, rst_ni, !(fire && is_end_i) || push_o)

endmodule

// ===== rtl/jbl_queue.sv =====
// Short FIFO of result bundles between front and back.
// Depends on jbl_pkg.
module jbl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jbl_pkg::bundle_t data_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output jbl_pkg::bundle_t data_o
);

  jbl_pkg::bundle_t [jbl_pkg::QueueDepth-1:0] mem_q;
  logic [jbl_pkg::QueueAw-1:0] wr_q, rd_q;
  logic [jbl_pkg::QueueCw-1:0] cnt_q;

  assign full_o  = (cnt_q == jbl_pkg::QueueCw'(jbl_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == jbl_pkg::QueueAw'(jbl_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == jbl_pkg::QueueAw'(jbl_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + jbl_pkg::QueueCw'(push_i) - jbl_pkg::QueueCw'(pop_i);
    end
  end

  `include "assert_macros.svh"
  `JBL_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && full_o))
  `JBL_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && empty_o))
  `JBL_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= jbl_pkg::QueueCw'(jbl_pkg::QueueDepth))

endmodule

// ===== rtl/jbl_back.sv =====
// Back end: unpacks bundles into single token transfers on the output port.
// Depends on jbl_pkg.
module jbl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  jbl_pkg::bundle_t data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [3:0]       token_kind_o,
  output logic [7:0]       content_byte_o,
  output logic [31:0]      line_number_o,
  output logic             last_of_run_o
);

  logic [1:0] idx_q;
  logic       last;

  assign out_valid_o    = !empty_i;
  assign token_kind_o   = data_i.tok[idx_q].kind;
  assign content_byte_o = data_i.tok[idx_q].data;
  assign line_number_o  = data_i.line;
  assign last           = (idx_q + 2'd1 == data_i.count);
  assign last_of_run_o  = last;
  assign pop_o          = out_valid_o && out_ready_i && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (out_valid_o && out_ready_i) idx_q <= last ? 2'd0 : idx_q + 2'd1;
  end

  `include "assert_macros.svh"
  `JBL_ASSERT(a_idx_range, clk_i, rst_ni, !out_valid_o || idx_q < data_i.count)
  `JBL_ASSERT_NEXT(a_idx_wrap, clk_i, rst_ni, pop_o, idx_q == 2'd0)
  `JBL_ASSERT(a_idle_idx, clk_i, rst_ni, out_valid_o || idx_q == 2'd0)

endmodule

// ===== rtl/json_byte_stream_lexer_core.sv =====
// Top level of the JSON byte stream lexer.
// Depends on jbl_pkg, jbl_front, jbl_queue, jbl_back.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_ready_o | text_byte_i, is_end_i
//  out     | output    | out_valid_o/out_ready_i | token_kind_o, content_byte_o,
//          |           |                        | line_number_o, last_of_run_o
//
// One input byte per cycle is taken whenever the two-entry bundle queue is not full.
// Each byte yields zero to three tokens; an unstalled back end sends one token per cycle,
// so sustained rate is one byte per cycle when bytes average at most one token.
// Reset (rst_ni low) returns the lexer to idle, line count zero, queue empty.
// Output stalls fill the queue and then deassert in_ready_o; no token is dropped.
module json_byte_stream_lexer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        is_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [7:0]  content_byte_o,
  output logic [31:0] line_number_o,
  output logic        last_of_run_o
);

  logic             push, full, empty, pop;
  jbl_pkg::bundle_t wbundle, rbundle;

  // Lexer state machine; writes one bundle per byte that makes tokens.
  jbl_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .text_byte_i, .is_end_i,
    .push_o(push), .bundle_o(wbundle), .full_i(full)
  );

  // Decouples lexing from output backpressure.
  jbl_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(wbundle), .full_o(full),
    .empty_o(empty), .pop_i(pop), .data_o(rbundle)
  );

  // Serializes each bundle into token transfers.
  jbl_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .data_i(rbundle), .pop_o(pop),
    .out_valid_o, .out_ready_i, .token_kind_o, .content_byte_o,
    .line_number_o, .last_of_run_o
  );

endmodule

// ===== test/json_byte_stream_lexer_core_tb.sv =====
// Testbench for json_byte_stream_lexer_core: directed and random JSON byte streams.
// Depends on jbl_pkg and the lexer RTL; a built-in lexer predicts every token.
`timescale 1ns / 1ps

module json_byte_stream_lexer_core_tb;

  // token as seen on the output channel
  typedef struct {
    logic [3:0]  kind;
    logic [7:0]  data;
    logic [31:0] line;
    logic        last;
  } tok_rec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  text_byte_i;
  logic        is_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  token_kind_o;
  logic [7:0]  content_byte_o;
  logic [31:0] line_number_o;
  logic        last_of_run_o;

  json_byte_stream_lexer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .is_end_i      (is_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .content_byte_o(content_byte_o),
    .line_number_o (line_number_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Lexer model state, kept in step with every accepted input transfer.
  // ---------------------------------------------------------------------------
  jbl_pkg::lex_mode_e lx_mode;
  logic [2:0]  lx_lit_pos;
  logic [1:0]  lx_lit_word;
  logic [2:0]  lx_num_phase;
  logic [15:0] lx_hex_acc;
  logic [2:0]  lx_hex_cnt;
  logic [1:0]  lx_u8_pend;
  logic [2:0]  lx_u8_class;
  logic [31:0] lx_lines;
  logic        lx_err;

  tok_rec_t    token_fifo[$];   // tokens still owed by the block
  tok_rec_t    step_toks[$];    // tokens of the byte being lexed
  int unsigned mismatches = 0;
  int unsigned tokens_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_pct_in;
  int unsigned idle_pct_out;
  bit          hold_off;        // receiver forced stall
  int unsigned quiet_cycles = 0;

  function automatic void emit(jbl_pkg::token_kind_e k, logic [7:0] d);
    tok_rec_t t;
    t.kind = k;
    t.data = d;
    t.line = lx_lines;
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void clear_sub();
    lx_mode      = jbl_pkg::M_IDLE;
    lx_lit_pos   = '0;
    lx_lit_word  = '0;
    lx_num_phase = '0;
    lx_hex_acc   = '0;
    lx_hex_cnt   = '0;
    lx_u8_pend   = '0;
    lx_u8_class  = '0;
  endfunction

  function automatic void flag_error();
    emit(jbl_pkg::TK_ERROR, 8'h00);
    clear_sub();
    lx_err = 1'b1;
  endfunction

  function automatic void bump_line();
    if (lx_lines != 32'hFFFF_FFFF) lx_lines = lx_lines + 32'd1;
  endfunction

  function automatic bit num_done();
    return lx_num_phase inside {3'd1, 3'd2, 3'd4, 3'd7};
  endfunction

  function automatic void lex_idle(logic [7:0] c);
    case (c)
      "[": emit(jbl_pkg::TK_LBRACKET, 8'h00);
      "{": emit(jbl_pkg::TK_LBRACE, 8'h00);
      ":": emit(jbl_pkg::TK_COLON, 8'h00);
      ",": emit(jbl_pkg::TK_COMMA, 8'h00);
      "}": emit(jbl_pkg::TK_RBRACE, 8'h00);
      "]": emit(jbl_pkg::TK_RBRACKET, 8'h00);
      " ", 8'h09, 8'h0D: ;
      8'h0A: bump_line();
      "\"": lx_mode = jbl_pkg::M_STRING;
      "t", "f", "n": begin
        lx_mode     = jbl_pkg::M_LITERAL;
        lx_lit_pos  = '0;
        lx_lit_word = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
      end
      "/": lx_mode = jbl_pkg::M_SLASH;
      default: begin
        if (c == "-" || (c >= "0" && c <= "9")) begin
          lx_mode      = jbl_pkg::M_NUMBER;
          lx_num_phase = (c == "-") ? 3'd0 : (c == "0") ? 3'd1 : 3'd2;
          emit(jbl_pkg::TK_CONTENT, c);
        end else begin
          flag_error();
        end
      end
    endcase
  endfunction

  function automatic void lex_number(logic [7:0] c);
    bit dig;
    bit ex;
    int nx;
    dig = c >= "0" && c <= "9";
    ex  = c == "e" || c == "E";
    nx  = -1;
    case (lx_num_phase)
      3'd0: if (c == "0") nx = 1; else if (dig) nx = 2;
      3'd1: if (c == ".") nx = 3; else if (ex) nx = 5;
      3'd2: if (dig) nx = 2; else if (c == ".") nx = 3; else if (ex) nx = 5;
      3'd3: if (dig) nx = 4;
      3'd4: if (dig) nx = 4; else if (ex) nx = 5;
      3'd5: if (c == "+" || c == "-") nx = 6; else if (dig) nx = 7;
      default: if (dig) nx = 7;
    endcase
    if (nx >= 0) begin
      lx_num_phase = nx[2:0];
      emit(jbl_pkg::TK_CONTENT, c);
    end else if (num_done()) begin
      emit(jbl_pkg::TK_NUM_END, 8'h00);
      clear_sub();
      lex_idle(c);
    end else begin
      flag_error();
    end
  endfunction

  function automatic void lex_string(logic [7:0] c);
    logic [7:0] lo;
    logic [7:0] hi;
    if (lx_u8_pend != 2'd0) begin
      lo = 8'h80;
      hi = 8'hBF;
      case (lx_u8_class)
        3'd1: lo = 8'hA0;
        3'd2: hi = 8'h9F;
        3'd3: lo = 8'h90;
        3'd4: hi = 8'h8F;
        default: ;
      endcase
      if (c < lo || c > hi) begin
        flag_error();
        return;
      end
      lx_u8_pend  = lx_u8_pend - 2'd1;
      lx_u8_class = '0;
      emit(jbl_pkg::TK_CONTENT, c);
      return;
    end
    if (c < 8'h20) begin
      flag_error();
      return;
    end
    if (c == "\"") begin
      emit(jbl_pkg::TK_STR_END, 8'h00);
      clear_sub();
      return;
    end
    if (c == "\\") begin
      lx_mode = jbl_pkg::M_ESCAPE;
      return;
    end
    if (c < 8'h80) begin
      emit(jbl_pkg::TK_CONTENT, c);
      return;
    end
    if (c >= 8'hC2 && c <= 8'hDF) begin
      lx_u8_pend = 2'd1; lx_u8_class = 3'd0;
    end else if (c == 8'hE0) begin
      lx_u8_pend = 2'd2; lx_u8_class = 3'd1;
    end else if (c == 8'hED) begin
      lx_u8_pend = 2'd2; lx_u8_class = 3'd2;
    end else if (c >= 8'hE1 && c <= 8'hEF) begin
      lx_u8_pend = 2'd2; lx_u8_class = 3'd0;
    end else if (c == 8'hF0) begin
      lx_u8_pend = 2'd3; lx_u8_class = 3'd3;
    end else if (c >= 8'hF1 && c <= 8'hF3) begin
      lx_u8_pend = 2'd3; lx_u8_class = 3'd0;
    end else if (c == 8'hF4) begin
      lx_u8_pend = 2'd3; lx_u8_class = 3'd4;
    end else begin
      flag_error();
      return;
    end
    emit(jbl_pkg::TK_CONTENT, c);
  endfunction

  function automatic void lex_escape(logic [7:0] c);
    logic [7:0] v;
    case (c)
      "\"", "\\", "/": v = c;
      "b": v = 8'h08;
      "f": v = 8'h0C;
      "n": v = 8'h0A;
      "r": v = 8'h0D;
      "t": v = 8'h09;
      "u": begin
        lx_mode    = jbl_pkg::M_HEX;
        lx_hex_acc = '0;
        lx_hex_cnt = '0;
        return;
      end
      default: begin
        flag_error();
        return;
      end
    endcase
    emit(jbl_pkg::TK_CONTENT, v);
    lx_mode = jbl_pkg::M_STRING;
  endfunction

  function automatic void lex_hex(logic [7:0] c);
    logic [3:0]  d;
    logic [15:0] x;
    if (c >= "0" && c <= "9") d = 4'(c - "0");
    else if (c >= "A" && c <= "F") d = 4'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "f") d = 4'(c - "a" + 8'd10);
    else begin
      flag_error();
      return;
    end
    lx_hex_acc = {lx_hex_acc[11:0], d};
    lx_hex_cnt = lx_hex_cnt + 3'd1;
    if (lx_hex_cnt < 3'd4) return;
    x = lx_hex_acc;
    if (x >= 16'hD800 && x <= 16'hDFFF) begin
      flag_error();
      return;
    end
    if (x < 16'h80) begin
      emit(jbl_pkg::TK_CONTENT, x[7:0]);
    end else if (x < 16'h800) begin
      emit(jbl_pkg::TK_CONTENT, 8'hC0 | x[10:6]);
      emit(jbl_pkg::TK_CONTENT, 8'h80 | x[5:0]);
    end else begin
      emit(jbl_pkg::TK_CONTENT, 8'hE0 | x[15:12]);
      emit(jbl_pkg::TK_CONTENT, 8'h80 | x[11:6]);
      emit(jbl_pkg::TK_CONTENT, 8'h80 | x[5:0]);
    end
    lx_hex_acc = '0;
    lx_hex_cnt = '0;
    lx_mode    = jbl_pkg::M_STRING;
  endfunction

  function automatic void lex_literal(logic [7:0] c);
    logic [7:0] want;
    logic [2:0] len;
    jbl_pkg::token_kind_e k;
    case (lx_lit_word)
      2'd0: begin
        want = 8'("rue" >> (8 * (2 - lx_lit_pos))); len = 3'd3; k = jbl_pkg::TK_TRUE;
      end
      2'd1: begin
        want = 8'("alse" >> (8 * (3 - lx_lit_pos))); len = 3'd4; k = jbl_pkg::TK_FALSE;
      end
      default: begin
        want = 8'("ull" >> (8 * (2 - lx_lit_pos))); len = 3'd3; k = jbl_pkg::TK_NULL;
      end
    endcase
    if (lx_lit_pos >= len || c != want) begin
      flag_error();
      return;
    end
    lx_lit_pos = lx_lit_pos + 3'd1;
    if (lx_lit_pos == len) begin
      emit(k, 8'h00);
      clear_sub();
    end
  endfunction

  function automatic void reset_lexer();
    clear_sub();
    lx_lines = '0;
    lx_err   = 1'b0;
  endfunction

  // Lex one accepted byte (or end marker) and queue its tokens.
  function automatic void lex_transfer(logic [7:0] c, logic fin);
    step_toks.delete();
    if (fin) begin
      if (!lx_err) begin
        if (lx_mode == jbl_pkg::M_NUMBER) begin
          emit(num_done() ? jbl_pkg::TK_NUM_END : jbl_pkg::TK_ERROR, 8'h00);
        end else if (lx_mode != jbl_pkg::M_IDLE && lx_mode != jbl_pkg::M_COMMENT) begin
          emit(jbl_pkg::TK_ERROR, 8'h00);
        end
      end
      emit(jbl_pkg::TK_EOF, 8'h00);
      reset_lexer();
    end else if (!lx_err) begin
      case (lx_mode)
        jbl_pkg::M_IDLE:    lex_idle(c);
        jbl_pkg::M_STRING:  lex_string(c);
        jbl_pkg::M_ESCAPE:  lex_escape(c);
        jbl_pkg::M_HEX:     lex_hex(c);
        jbl_pkg::M_LITERAL: lex_literal(c);
        jbl_pkg::M_NUMBER:  lex_number(c);
        jbl_pkg::M_SLASH:   if (c == "/") lx_mode = jbl_pkg::M_COMMENT; else flag_error();
        default:   if (c == 8'h0A) begin bump_line(); lx_mode = jbl_pkg::M_IDLE; end
      endcase
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) token_fifo.push_back(step_toks[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transfers, compare on output transfers.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tok_rec_t exp_t;
    if (rst_ni && in_valid_i && in_ready_o) lex_transfer(text_byte_i, is_end_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      tokens_seen++;
      if (token_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token kind=%0d data=%h", token_kind_o, content_byte_o);
      end else begin
        exp_t = token_fifo.pop_front();
        if (token_kind_o !== exp_t.kind || content_byte_o !== exp_t.data ||
            line_number_o !== exp_t.line || last_of_run_o !== exp_t.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("token %0d: exp kind=%0d data=%h line=%0d last=%b, got %0d %h %0d %b",
                     tokens_seen, exp_t.kind, exp_t.data, exp_t.line, exp_t.last,
                     token_kind_o, content_byte_o, line_number_o, last_of_run_o);
        end
      end
    end
  end

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !hold_off && ($urandom_range(99) >= idle_pct_out);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("json_byte_stream_lexer_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Valid stays up between back-to-back bytes; it drops only in idle gaps.
  task automatic send_byte(logic [7:0] b, logic fin = 1'b0);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    is_end_i    <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_end();
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // Sender stops and waits until every predicted token has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (token_fifo.size() != 0);
  endtask

  task automatic test_directed();
    send_text("[{:,}]\t\r \n");
    send_text("true false null");
    send_end();
    send_text("\"a\\\"\\\\\\/\\b\\f\\n\\r\\t\\u0041\\u00e9\\uFFFF\"");
    send_text("\"\xC3\xA9\xE0\xA0\x80\xED\x9F\xBF\xF0\x90\x80\x80\xF4\x8F\xBF\xBF\"");
    send_end();
    send_text("-0.5e+3 12E7,0 // note\n-");
    send_end();                           // incomplete number at end
    send_text("\"\\uD800");               // surrogate rejected
    send_end();
    send_text("/x"); send_end();          // lone slash
    send_text("tx"); send_end();          // bad literal
    send_text("\"\x01"); send_end();      // control byte
    send_text("\"\xC3\""); send_end();    // quote while continuation pending
    send_text("\"\xC0"); send_end();      // invalid lead
    send_byte(8'h00); send_byte(8'hFF); send_end();
    send_text("1-"); send_end();
    send_text("\"ab"); send_end();        // unterminated string
  endtask

  // Mostly well-formed JSON fragments with random content, some noise.
  task automatic send_random_fragment();
    int unsigned sel;
    string hex_digits;
    hex_digits = "0123456789abcdefABCDEF";
    sel = $urandom_range(9);
    case (sel)
      0: send_text("{\"k\":");
      1: begin
        send_byte("\"");
        repeat ($urandom_range(4)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
        if ($urandom_range(1)) begin
          send_text("\\u");
          repeat (4) send_byte(hex_digits[$urandom_range(21)]);
        end
        if ($urandom_range(1)) send_byte(8'(8'hC2 + $urandom_range(29)));
        send_byte($urandom_range(1) ? 8'(8'h80 + $urandom_range(63)) : 8'h22);
        send_byte("\"");
      end
      2: begin
        if ($urandom_range(1)) send_byte("-");
        repeat ($urandom_range(1, 3)) send_byte(8'("0" + $urandom_range(9)));
        if ($urandom_range(1)) send_text(".5");
        if ($urandom_range(1)) begin
          if ($urandom_range(1)) send_text("e-");
          else send_text("E");
        end
        send_byte(8'("0" + $urandom_range(9)));
        send_byte(",");
      end
      3: begin
        if ($urandom_range(1)) send_text("true,");
        else send_text("null]");
      end
      4: send_text("false\n");
      5: send_text("// c\xFF\n");
      6: send_byte(8'($urandom_range(255)));
      7: send_text("[ ] ");
      8: send_end();
      default: send_text("\"\\x");
    endcase
  endtask

  task automatic test_random(int unsigned n);
    int unsigned stop;
    stop = bytes_sent + n;
    while (bytes_sent < stop) send_random_fragment();
    send_end();
  endtask

  // Receiver stalls for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_text("\"\\u20AC\\u20AC\"");
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    join
    send_end();
    wait_drained();
  endtask

  initial begin
    in_valid_i   = 1'b0;
    text_byte_i  = '0;
    is_end_i     = 1'b0;
    hold_off     = 1'b0;
    idle_pct_in  = 12;
    idle_pct_out = 70;
    reset_lexer();
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    wait_drained();                      // sender pauses until all tokens are back
    idle_pct_in  = 70;
    idle_pct_out = 12;
    test_random(8);
    idle_pct_in  = 0;
    idle_pct_out = 0;
    test_backpressure();
    test_random(8);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d input transfers and %0d tokens: punctuation, strings, escapes,",
             bytes_sent, tokens_seen);
    $display("UTF-8, numbers, literals, comments, errors and end markers under stalls");
    if (mismatches == 0 && token_fifo.size() == 0) begin
      $display("json_byte_stream_lexer_core: match");
    end else begin
      $display("json_byte_stream_lexer_core: mismatch");
    end
    $finish;
  end

endmodule
